### src/ipsct_pkg.sv
// Shared types and constants for the IPv4 source counter table.
// No dependencies; imported by the top unit, the sequencer and the testbench.
package ipsct_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 256;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int ENT_W  = 9;
  localparam int MEM_W  = ADDR_W + CNT_W;

  // Opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Result of one item, handed from the sequencer to the output stage
  typedef struct packed {
    logic              status;
    logic              hit;
    logic [CNT_W-1:0]  new_count;
    logic [ENT_W-1:0]  entries;
  } res_t;

endpackage

### src/ipv4_source_counter_table_unit.sv
// IPv4 source counter table: exact-match lookup with per-address 32-bit count.
// A clear goes straight to the result register; an add on an empty table goes straight to
// allocation; otherwise the RAM scan reads the entries in use at 1/cycle, stopping on a hit.
// One item in work at a time; the next beat is taken the cycle after the result moves to
// the output register. Reset (rst_n low, synchronous) clears the fill count, the sequencer
// state and the output valid flag; the table RAM keeps its contents. Uses ipsct_pkg/_ram/_seq.
module ipv4_source_counter_table_unit #(
  parameter int TABLE_ENTRIES = ipsct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [ipsct_pkg::ADDR_W-1:0] in_address,
  input  logic [ipsct_pkg::CNT_W-1:0]  in_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic                        out_hit,
  output logic [ipsct_pkg::CNT_W-1:0]  out_new_count,
  output logic [ipsct_pkg::ENT_W-1:0]  out_entries_in_use
);
  import ipsct_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;
  logic             res_valid, res_take;
  res_t             res;

  logic             out_valid_r;
  res_t             out_r;

  // key/count table, key in the upper half of each word
  ipsct_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipsct_seq #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_address (in_address),
    .in_amount  (in_amount),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_hit            = out_r.hit;
  assign out_new_count      = out_r.new_count;
  assign out_entries_in_use = out_r.entries;

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  // a hit is never reported as table full
  a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.hit |-> res.status == ST_DONE)
    else $error("hit reported with full status");

  // full result carries no count
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == ST_FULL |-> !res.hit && res.new_count == '0)
    else $error("full result with hit or count");

  // handing a result over always fills the output register
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid)
    else $error("result lost at output register");

endmodule

### src/ipsct_ram.sv
// Simple dual-port table RAM: one write port, one registered read port.
// Depends on nothing but its parameters.
module ipsct_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ipsct_seq.sv
// Sequencer for the counter table: clears, or scans any stored keys one per cycle
// through the shared compare/add unit, then updates, allocates or flags full. Uses ipsct_pkg.
module ipsct_seq #(
  parameter int ENTRIES = ipsct_pkg::TABLE_ENTRIES_DEF,
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input beat
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [ipsct_pkg::ADDR_W-1:0] in_address,
  input  logic [ipsct_pkg::CNT_W-1:0]  in_amount,
  // result toward the output stage
  output logic                        res_valid,
  output ipsct_pkg::res_t             res,
  input  logic                        res_take,
  // table RAM
  output logic                        ram_we,
  output logic [IW-1:0]               ram_waddr,
  output logic [ipsct_pkg::MEM_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [IW-1:0]               ram_raddr,
  input  logic [ipsct_pkg::MEM_W-1:0] ram_rdata
);
  import ipsct_pkg::*;

  localparam int UW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  amt_r, amt_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic              last_r, last_nxt;
  res_t              res_r, res_nxt;

  // shared compare and add unit on the entry read back
  logic              match_w;
  logic [CNT_W-1:0]  sum_w;
  logic              full_w;
  logic [UW-1:0]     used_inc_w;

  assign match_w    = pend_r && (ram_rdata[MEM_W-1 -: ADDR_W] == addr_r);
  assign sum_w      = ram_rdata[CNT_W-1:0] + amt_r;
  assign full_w     = (used_r == UW'(ENTRIES));
  assign used_inc_w = used_r + UW'(1);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    amt_nxt   = amt_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {addr_r, amt_r};
    ram_re    = 1'b0;
    ram_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt = in_address;
          amt_nxt  = in_amount;
          if (in_opcode == OP_CLEAR) begin
            used_nxt          = '0;
            res_nxt.status    = ST_DONE;
            res_nxt.hit       = 1'b0;
            res_nxt.new_count = '0;
            res_nxt.entries   = '0;
            state_nxt         = S_POST;
          end else if (used_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            last_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle; valid entries are exactly 0..used-1
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        pend_nxt  = 1'b1;
        pidx_nxt  = idx_r;
        last_nxt  = (UW'(idx_r) == used_r - UW'(1));
        if (!last_nxt) begin
          idx_nxt = idx_r + IW'(1);
        end
        // compare the entry read last cycle
        if (match_w) begin
          ram_we            = 1'b1;
          ram_waddr         = pidx_r;
          ram_wdata         = {addr_r, sum_w};
          res_nxt.status    = ST_DONE;
          res_nxt.hit       = 1'b1;
          res_nxt.new_count = sum_w;
          res_nxt.entries   = ENT_W'(used_r);
          state_nxt         = S_POST;
        end else if (pend_r && last_r) begin
          state_nxt = S_MISS;
        end
      end

      S_MISS: begin
        res_nxt.hit = 1'b0;
        if (full_w) begin
          res_nxt.status    = ST_FULL;
          res_nxt.new_count = '0;
          res_nxt.entries   = ENT_W'(used_r);
        end else begin
          // allocate the lowest free entry, which is the fill count
          ram_we            = 1'b1;
          ram_waddr         = used_r[IW-1:0];
          ram_wdata         = {addr_r, amt_r};
          used_nxt          = used_inc_w;
          res_nxt.status    = ST_DONE;
          res_nxt.new_count = amt_r;
          res_nxt.entries   = ENT_W'(used_inc_w);
        end
        state_nxt = S_POST;
      end

      S_POST: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    amt_r  <= amt_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_POST);
  assign res       = res_r;

endmodule

### test/ipv4_source_counter_table_unit_test.sv
// Testbench for ipv4_source_counter_table_unit: directed edge cases, a full table,
// output back-pressure and random traffic, all checked against an in-bench tally model.
// Depends on ipsct_pkg and the RTL of ipv4_source_counter_table_unit.
`timescale 1ns / 100ps

module ipv4_source_counter_table_unit_test;
  import ipsct_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 40;
  localparam int HOLD_OFF_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OP_ADD;
  logic [ADDR_W-1:0] in_address = '0;
  logic [CNT_W-1:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic out_hit;
  logic [CNT_W-1:0] out_new_count;
  logic [ENT_W-1:0] out_entries_in_use;

  // Tally model state
  logic [ADDR_W-1:0] tally_key [TABLE_ENTRIES];
  logic [CNT_W-1:0] tally_count [TABLE_ENTRIES];
  bit tally_live [TABLE_ENTRIES];
  int unsigned tally_used;

  res_t pending_tallies[$];

  // Idle and stall rates in percent, plus a long receiver hold-off request
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hits_seen = 0;
  int unsigned fulls_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned idle_cycles = 0;

  ipv4_source_counter_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_address(in_address),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_hit(out_hit),
    .out_new_count(out_new_count),
    .out_entries_in_use(out_entries_in_use)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Expected result of one accepted beat; updates the tally state
  function automatic res_t predict_tally(logic op, logic [ADDR_W-1:0] addr,
                                         logic [CNT_W-1:0] amt);
    res_t r;
    int found;
    int free_slot;
    r = '0;
    found = -1;
    free_slot = -1;
    if (op == OP_CLEAR) begin
      foreach (tally_live[i]) tally_live[i] = 1'b0;
      tally_used = 0;
      clears_seen++;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tally_live[i]) begin
          if (found < 0 && tally_key[i] == addr) found = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (found >= 0) begin
        tally_count[found] = tally_count[found] + amt;
        r.hit = 1'b1;
        r.new_count = tally_count[found];
        hits_seen++;
      end else if (free_slot >= 0) begin
        tally_live[free_slot] = 1'b1;
        tally_key[free_slot] = addr;
        tally_count[free_slot] = amt;
        tally_used++;
        r.new_count = amt;
      end else begin
        r.status = ST_FULL;
        fulls_seen++;
      end
    end
    r.entries = tally_used[ENT_W-1:0];
    return r;
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_beat(logic op, logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] amt);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_amount <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_tallies.push_back(predict_tally(op, addr, amt));
    beats_sent++;
  endtask

  task automatic test_directed_edges();
    send_beat(OP_CLEAR, '1, '1);              // clear an empty table
    send_beat(OP_ADD, '0, '0);                // zero amount miss still allocates
    send_beat(OP_ADD, '0, '0);                // zero amount hit keeps count
    send_beat(OP_ADD, '0, 32'd1);
    send_beat(OP_ADD, '1, '1);
    send_beat(OP_ADD, '1, 32'd1);             // wraps to zero
    send_beat(OP_ADD, '1, '1);
    send_beat(OP_ADD, '1, '1);                // wraps past max
    send_beat(OP_ADD, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_ADD, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_ADD, 32'h0000_0001, 32'h7FFF_FFFF);
    send_beat(OP_ADD, 32'hC0A8_0001, 32'd1);
    send_beat(OP_ADD, 32'hC0A8_0002, 32'd1);
    send_beat(OP_ADD, 32'hC0A8_0001, 32'd1);
    send_beat(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_beat(OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(OP_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0);
    send_beat(OP_ADD, 32'hC0A8_0001, 32'd5);  // same key after clear is a miss
    send_beat(OP_ADD, '1, 32'd3);
    send_beat(OP_CLEAR, '0, '0);
  endtask

  // Fill every entry, then miss on a full table and hit on a stored key
  task automatic test_table_full();
    logic [ADDR_W-1:0] base;
    base = $urandom;
    send_beat(OP_CLEAR, '0, '0);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      send_beat(OP_ADD, base ^ ADDR_W'(i), ($urandom_range(3) == 0) ? $urandom : 32'd1);
    end
    send_beat(OP_ADD, ~base, 32'd1);
    send_beat(OP_ADD, base ^ ADDR_W'(TABLE_ENTRIES - 1), 32'd1);
    send_beat(OP_ADD, base, '1);
    send_beat(OP_ADD, base ^ ADDR_W'(TABLE_ENTRIES), 32'd7);
    send_beat(OP_CLEAR, base, '0);
    send_beat(OP_ADD, ~base, 32'd2);
  endtask

  // Receiver holds off for a long stretch while beats keep coming
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_beat(OP_ADD, 32'h0A00_0000 | ($urandom_range(3) << 4), 32'd1);
    end
  endtask

  task automatic test_random_traffic(int unsigned beats, int unsigned idle_pct,
                                     int unsigned stall_pct);
    logic [ADDR_W-1:0] recent [16];
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0] amt;
    logic op;
    int unsigned roll;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (recent[i]) recent[i] = $urandom;
    for (int unsigned n = 0; n < beats; n++) begin
      roll = $urandom_range(99);
      op = OP_ADD;
      addr = $urandom;
      if (roll < 3) begin
        op = OP_CLEAR;
      end else if (roll < 65) begin
        addr = recent[$urandom_range(15)];   // likely hit
      end else begin
        recent[$urandom_range(15)] = addr;
      end
      case ($urandom_range(3))
        0: amt = 32'd1;
        1: amt = $urandom;
        2: amt = '1 - $urandom_range(3);
        default: amt = $urandom_range(15);
      endcase
      send_beat(op, addr, amt);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker
  initial begin
    res_t want;
    res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        got = '{out_status, out_hit, out_new_count, out_entries_in_use};
        if (pending_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = pending_tallies.pop_front();
          if (got.status !== want.status || got.hit !== want.hit ||
              got.new_count !== want.new_count || got.entries !== want.entries) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: status %0b/%0b hit %0b/%0b count %h/%h entries %0d/%0d",
                       results_seen, want.status, got.status, want.hit, got.hit,
                       want.new_count, got.new_count, want.entries, got.entries);
            end
          end
        end
      end
    end
  end

  // Watchdog: cycles without any accepted beat on either side
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout after %0d idle cycles", idle_cycles);
    $display("ipv4_source_counter_table_unit: mismatch");
    $finish;
  end

  initial begin
    foreach (tally_live[i]) tally_live[i] = 1'b0;
    tally_used = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_table_full();
    test_output_hold_off();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 75, 0);
    test_random_traffic(500, 0, 75);
    test_random_traffic(500, 6, 6);

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tallies.size() != 0) mismatches++;

    $display("%0d beats sent, %0d results checked, %0d mismatches",
             beats_sent, results_seen, mismatches);
    $display("covered %0d hits, %0d full-table misses, %0d clears",
             hits_seen, fulls_seen, clears_seen);
    if (mismatches == 0) begin
      $display("ipv4_source_counter_table_unit: match");
    end else begin
      $display("ipv4_source_counter_table_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
src/ipsct_pkg.sv
src/ipsct_ram.sv
src/ipsct_seq.sv
src/ipv4_source_counter_table_unit.sv
test/ipv4_source_counter_table_unit_test.sv
